@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, rhs holds.
`define CC_ASSERT_NOW(lbl, cond, rhs, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (rhs)) \
		else $error(msg);

// Next-cycle implication: when cond holds, rhs holds in the next cycle.
`define CC_ASSERT_NEXT(lbl, cond, rhs, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (rhs)) \
		else $error(msg);

`endif

@@ hdl/cc20_pkg.sv @@
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and round functions for the ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
package cc20_pkg;

	localparam int DATA_W    = 64;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int WORDS     = 8;   // 64-bit keystream words per block
	localparam int POS_W     = 3;

	typedef logic [31:0]         word_t;
	typedef word_t [15:0]        state_t;
	typedef word_t [3:0]         quad_t;
	typedef logic [DATA_W-1:0]   dword_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// "expand 32-byte k"
	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	localparam cnt_t FULL_COUNT = 4'd8;

	// Configuration register indexes
	localparam cfg_idx_t REG_KEY01   = 3'd0;
	localparam cfg_idx_t REG_KEY23   = 3'd1;
	localparam cfg_idx_t REG_KEY45   = 3'd2;
	localparam cfg_idx_t REG_KEY67   = 3'd3;
	localparam cfg_idx_t REG_NONCE01 = 3'd4;
	localparam cfg_idx_t REG_NONCE2  = 3'd5;
	localparam cfg_idx_t REG_COUNTER = 3'd6;

	// Controller to datapath commands
	typedef struct packed {
		logic emit_now;   // keystream held: XOR the incoming word straight away
		logic start;      // no keystream: load the working state
		logic round_en;   // apply one round to the working state
		logic diag;       // 0 column round, 1 diagonal round
		logic finish;     // feed-forward add, store keystream, bump counter
		logic emit_held;  // XOR the latched word after a fresh block
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic blk_valid;  // keystream block available for the next word
		logic out_free;   // output register can take a word this cycle
	} dp_stat_t;

	function automatic word_t rotl(input word_t v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

	function automatic quad_t quarter_round(input quad_t q);
		word_t a, b, c, d;
		a = q[0]; b = q[1]; c = q[2]; d = q[3];
		a = a + b; d = rotl(d ^ a, 16);
		c = c + d; b = rotl(b ^ c, 12);
		a = a + b; d = rotl(d ^ a, 8);
		c = c + d; b = rotl(b ^ c, 7);
		quarter_round = {d, c, b, a};
	endfunction

	// One column round (diag = 0) or one diagonal round (diag = 1).
	// Called with a constant diag, so the index selection folds away.
	function automatic state_t chacha_round(input state_t x, input bit diag);
		state_t y;
		quad_t  q;
		int     ib, ic, id;
		y = x;
		for (int i = 0; i < 4; i++) begin
			ib = 4  + (diag ? ((i + 1) & 3) : i);
			ic = 8  + (diag ? ((i + 2) & 3) : i);
			id = 12 + (diag ? ((i + 3) & 3) : i);
			q = quarter_round({x[id], x[ic], x[ib], x[i]});
			y[i]  = q[0];
			y[ib] = q[1];
			y[ic] = q[2];
			y[id] = q[3];
		end
		chacha_round = y;
	endfunction

endpackage

@@ hdl/cc20_in_if.sv @@
// ----------------------------------------------------------------------------
// cc20_in_if
// Input channel: one 64-bit data word with its byte count and end flag.
// ----------------------------------------------------------------------------
interface cc20_in_if;
	logic                 valid;
	logic                 ready;
	cc20_pkg::dword_t     data_in;
	cc20_pkg::cnt_t       byte_count;
	logic                 end_of_message;

	modport source (output valid, output data_in, output byte_count,
		output end_of_message, input ready);
	modport sink (input valid, input data_in, input byte_count,
		input end_of_message, output ready);
endinterface

@@ hdl/cc20_out_if.sv @@
// ----------------------------------------------------------------------------
// cc20_out_if
// Output channel: one 64-bit result word with its byte count and end flag.
// ----------------------------------------------------------------------------
interface cc20_out_if;
	logic                 valid;
	logic                 ready;
	cc20_pkg::dword_t     data_out;
	cc20_pkg::cnt_t       byte_count_out;
	logic                 last_out;

	modport source (output valid, output data_out, output byte_count_out,
		output last_out, input ready);
	modport sink (input valid, input data_out, input byte_count_out,
		input last_out, output ready);
endinterface

@@ hdl/chacha20_stream_xor.sv @@
// ChaCha20 stream XOR (IETF layout, 96-bit nonce), one 64-bit word per transaction.
// Configuration: write key, nonce and initial counter through cfg_we/cfg_index/
//   cfg_data while no word is in flight. Writing the nonce or counter restarts
//   the block counter; a key write takes effect at the next block.
// in_ch carries data_in (byte 0 in the low bits), byte_count and end_of_message;
//   out_ch returns data_out with bytes past the count zeroed, the count
//   (saturated to 8) and last_out.
// Output timing: a word that uses an already computed keystream block appears in
//   the cycle after acceptance. The first word of a block waits for the round unit:
//   the working state is loaded, one round runs per cycle, then the feed-forward
//   add, then the output register once it is free.
// Flow: no new word is accepted while a fresh block runs its rounds, feed-forward
//   add and emit step; the round unit is reused for every round of the block.
// A message end or a short word closes the block; the next word starts a new
//   block with the next counter value.
// Reset: control, configuration, counter and nonce state clear to zero; no fill pass.
// Stall: the output register holds its word until taken; in_ch.ready drops while
//   a held-keystream word cannot be placed, and a fresh block waits after its
//   rounds until the output register frees up.
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// Top level: controller and datapath of the ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
module chacha20_stream_xor #(
	parameter int ROUNDS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  cc20_pkg::cfg_idx_t cfg_index,
	input  cc20_pkg::dword_t   cfg_data,
	cc20_in_if.sink            in_ch,
	cc20_out_if.source         out_ch
);

	cc20_pkg::dp_cmd_t  cmd;
	cc20_pkg::dp_stat_t stat;
	logic               in_ready;

	assign in_ch.ready = in_ready;

	cc20_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cc20_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.data_in        (in_ch.data_in),
		.byte_count     (in_ch.byte_count),
		.end_of_message (in_ch.end_of_message),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.data_out       (out_ch.data_out),
		.byte_count_out (out_ch.byte_count_out),
		.last_out       (out_ch.last_out)
	);

endmodule

@@ hdl/cc20_ctrl.sv @@
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts words, runs the round count for a fresh block, and
// schedules the XOR into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cc20_ctrl #(
	parameter int ROUNDS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cc20_pkg::dp_stat_t stat,
	output cc20_pkg::dp_cmd_t  cmd
);

	localparam int RND_W = $clog2(ROUNDS);
	localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [RND_W-1:0] rnd_q, rnd_d;
	logic             accept;

	// Held keystream needs a free output slot; a fresh block does not
	assign in_ready = (state_q == ST_IDLE) && (!stat.blk_valid || stat.out_free);
	assign accept   = in_valid && in_ready;

	// Command decode
	always_comb begin
		cmd           = '0;
		cmd.emit_now  = accept && stat.blk_valid;
		cmd.start     = accept && !stat.blk_valid;
		cmd.round_en  = (state_q == ST_ROUND);
		cmd.diag      = rnd_q[0];
		cmd.finish    = (state_q == ST_ADD);
		cmd.emit_held = (state_q == ST_EMIT) && stat.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		rnd_d   = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				rnd_d = '0;
				if (cmd.start) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				rnd_d = rnd_q + 1'b1;
				if (rnd_q == RND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end

	// Checks
	`CC_ASSERT_NEXT(a_start_runs_rounds, cmd.start, state_q == ST_ROUND && rnd_q == '0,
		"fresh block did not enter the round loop at round zero")
	`CC_ASSERT_NEXT(a_add_then_emit, state_q == ST_ADD, state_q == ST_EMIT,
		"feed-forward add not followed by the emit step")

endmodule

@@ hdl/cc20_core.sv @@
// ----------------------------------------------------------------------------
// cc20_core
// Datapath: configuration registers, counter and nonce state, the working
// state with its round unit, the keystream block and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cc20_core (
	input  logic                clk,
	input  logic                arst_n,
	input  cc20_pkg::dp_cmd_t   cmd,
	output cc20_pkg::dp_stat_t  stat,
	input  logic                cfg_we,
	input  cc20_pkg::cfg_idx_t  cfg_index,
	input  cc20_pkg::dword_t    cfg_data,
	input  cc20_pkg::dword_t    data_in,
	input  cc20_pkg::cnt_t      byte_count,
	input  logic                end_of_message,
	input  logic                out_ready,
	output logic                out_valid,
	output cc20_pkg::dword_t    data_out,
	output cc20_pkg::cnt_t      byte_count_out,
	output logic                last_out
);

	cc20_pkg::dword_t              key_q [4];
	cc20_pkg::dword_t              nonce01_q;
	cc20_pkg::word_t               nonce2_q;
	cc20_pkg::word_t               ctr_init_q;
	cc20_pkg::word_t               blk_ctr_q;
	cc20_pkg::word_t               carry_q;
	logic                          blk_valid_q;
	logic [cc20_pkg::POS_W-1:0]    pos_q;
	logic                          out_valid_q;

	cc20_pkg::state_t              x_q;
	cc20_pkg::dword_t              ks_q [cc20_pkg::WORDS];
	cc20_pkg::dword_t              hold_data_q;
	cc20_pkg::cnt_t                hold_cnt_q;
	logic                          hold_last_q;
	cc20_pkg::dword_t              data_out_q;
	cc20_pkg::cnt_t                cnt_out_q;
	logic                          last_out_q;

	cc20_pkg::state_t              init_st;
	cc20_pkg::state_t              col_st, diag_st;
	logic                          emit;
	logic                          reload;
	cc20_pkg::dword_t              src_data;
	cc20_pkg::cnt_t                src_cnt;
	logic                          src_last;
	cc20_pkg::cnt_t                cnt_sat;
	cc20_pkg::dword_t              mask;
	logic                          blk_end;

	assign emit     = cmd.emit_now || cmd.emit_held;
	assign reload   = cfg_we && (cfg_index == cc20_pkg::REG_NONCE01 ||
		cfg_index == cc20_pkg::REG_NONCE2 || cfg_index == cc20_pkg::REG_COUNTER);

	assign stat.blk_valid = blk_valid_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	// Block input state
	always_comb begin
		init_st[0] = cc20_pkg::SIGMA0;
		init_st[1] = cc20_pkg::SIGMA1;
		init_st[2] = cc20_pkg::SIGMA2;
		init_st[3] = cc20_pkg::SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_st[4 + 2 * i] = key_q[i][31:0];
			init_st[5 + 2 * i] = key_q[i][63:32];
		end
		init_st[12] = blk_ctr_q;
		init_st[13] = carry_q;
		init_st[14] = nonce01_q[63:32];
		init_st[15] = nonce2_q;
	end

	// Round unit: one column or diagonal round per cycle
	assign col_st  = cc20_pkg::chacha_round(x_q, 1'b0);
	assign diag_st = cc20_pkg::chacha_round(x_q, 1'b1);

	// Word source, count saturation and byte mask
	assign src_data = cmd.emit_now ? data_in        : hold_data_q;
	assign src_cnt  = cmd.emit_now ? byte_count     : hold_cnt_q;
	assign src_last = cmd.emit_now ? end_of_message : hold_last_q;
	assign cnt_sat  = (src_cnt > cc20_pkg::FULL_COUNT) ? cc20_pkg::FULL_COUNT : src_cnt;
	assign blk_end  = src_last || (cnt_sat < cc20_pkg::FULL_COUNT) ||
		(pos_q == cc20_pkg::POS_W'(cc20_pkg::WORDS - 1));

	always_comb begin
		for (int b = 0; b < cc20_pkg::WORDS; b++) begin
			mask[8 * b +: 8] = {8{cc20_pkg::CNT_W'(b) < cnt_sat}};
		end
	end

	// Configuration, counter and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			nonce01_q   <= '0;
			nonce2_q    <= '0;
			ctr_init_q  <= '0;
			blk_ctr_q   <= '0;
			carry_q     <= '0;
			blk_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cc20_pkg::REG_KEY01:   key_q[0]   <= cfg_data;
					cc20_pkg::REG_KEY23:   key_q[1]   <= cfg_data;
					cc20_pkg::REG_KEY45:   key_q[2]   <= cfg_data;
					cc20_pkg::REG_KEY67:   key_q[3]   <= cfg_data;
					cc20_pkg::REG_NONCE01: begin
						nonce01_q <= cfg_data;
						carry_q   <= cfg_data[31:0];
						blk_ctr_q <= ctr_init_q;
					end
					cc20_pkg::REG_NONCE2: begin
						nonce2_q  <= cfg_data[31:0];
						carry_q   <= nonce01_q[31:0];
						blk_ctr_q <= ctr_init_q;
					end
					cc20_pkg::REG_COUNTER: begin
						ctr_init_q <= cfg_data[31:0];
						carry_q    <= nonce01_q[31:0];
						blk_ctr_q  <= cfg_data[31:0];
					end
					default: begin
					end
				endcase
			end
			priority if (reload) begin
				blk_valid_q <= 1'b0;
				pos_q       <= '0;
			end else if (cmd.finish) begin
				// Counter wraps at 32 bits and carries into state word 13
				blk_ctr_q   <= blk_ctr_q + 32'd1;
				if (blk_ctr_q == '1) begin
					carry_q <= carry_q + 32'd1;
				end
				blk_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (emit) begin
				if (blk_end) begin
					blk_valid_q <= 1'b0;
					pos_q       <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Working state, keystream, held word and output payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q         <= init_st;
			hold_data_q <= data_in;
			hold_cnt_q  <= byte_count;
			hold_last_q <= end_of_message;
		end else if (cmd.round_en) begin
			x_q <= cmd.diag ? diag_st : col_st;
		end
		if (cmd.finish) begin
			for (int w = 0; w < cc20_pkg::WORDS; w++) begin
				ks_q[w] <= {x_q[2 * w + 1] + init_st[2 * w + 1], x_q[2 * w] + init_st[2 * w]};
			end
		end
		if (emit) begin
			data_out_q <= (src_data ^ ks_q[pos_q]) & mask;
			cnt_out_q  <= cnt_sat;
			last_out_q <= src_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_out       = data_out_q;
	assign byte_count_out = cnt_out_q;
	assign last_out       = last_out_q;

	// Checks
	`CC_ASSERT_NOW(a_emit_has_block, emit, blk_valid_q,
		"word XORed without a keystream block")
	`CC_ASSERT_NEXT(a_finish_sets_block, cmd.finish, blk_valid_q && pos_q == '0,
		"new keystream block not marked valid at word zero")
	`CC_ASSERT_NOW(a_emit_slot_free, emit, !out_valid_q || out_ready,
		"output register overwritten while its word waits")

endmodule
